// ----- rtl/prime_sieve_lister_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the prime sieve lister
// Concurrent checks on clk, disabled while rst_n is low; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef PRIME_SIEVE_LISTER_CORE_ASSERT_SVH
`define PRIME_SIEVE_LISTER_CORE_ASSERT_SVH
`ifndef SYNTH
`define PSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PSL_ASSERT(lbl, prop, msg)
`define PSL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/psl_pkg.sv -----
// ----------------------------------------------------------------------------
// psl_pkg
// Shared constants and controller/datapath interface types of the sieve lister.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psl_pkg;

  localparam int MAX_LIMIT_DEF = 1023;

  localparam int LIMIT_W = 10;
  localparam int VALUE_W = 10;
  localparam int COUNT_W = 8;
  localparam int EMIT_W  = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
  localparam logic [EMIT_W-1:0]  EMIT_RESET = 6'd63;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_EMITTED = 2'd0;

  typedef struct packed {
    logic accept;
    logic init_wr;
    logic rd;
    logic count;
    logic emit;
    logic strike_start;
    logic strike_wr;
    logic p_step;
    logic summary;
  } psl_cmd_t;

  typedef struct packed {
    logic lim_small;
    logic idx_done;
    logic mark;
    logic sq_le;
    logic strike_done;
    logic p_last;
    logic need_emit;
    logic slot_free;
  } psl_sts_t;

endpackage

// ----- rtl/psl_ram.sv -----
// ----------------------------------------------------------------------------
// psl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psl_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/psl_datapath.sv -----
// ----------------------------------------------------------------------------
// psl_datapath
// Sieve indices, mark store, prime counters and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psl_datapath
  import psl_pkg::*;
#(
  parameter int MAX_LIMIT = MAX_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  psl_cmd_t           cmd,
  output psl_sts_t           sts,
  input  logic [EMIT_W-1:0]  max_emitted,
  input  logic [LIMIT_W-1:0] in_limit,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [VALUE_W-1:0] out_prime_value,
  output logic               out_is_prime_item,
  output logic [COUNT_W-1:0] out_prime_count,
  output logic               out_last
);

  localparam int IW = $clog2(MAX_LIMIT + 1);
  localparam int LW = (IW > LIMIT_W) ? IW : LIMIT_W;
  localparam int PW = (IW > VALUE_W) ? IW : VALUE_W;

  logic [IW-1:0]      lim_r, lim_nxt;
  logic [IW-1:0]      i_r, i_nxt;
  logic [IW-1:0]      p_r, p_nxt;
  logic [IW:0]        m_r, m_nxt;
  logic [2*IW-1:0]    sq_r;
  logic [COUNT_W-1:0] found_r, found_nxt, found_inc;
  logic [EMIT_W-1:0]  emitted_r, emitted_nxt;
  logic [LW-1:0]      lim_wide, lim_sat;
  logic [IW:0]        m_sum;
  logic [PW-1:0]      p_wide;

  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_item_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_last_r;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic               ram_wdata;
  logic               ram_rdata;

  assign lim_wide  = LW'(in_limit);
  assign lim_sat   = (lim_wide > LW'(MAX_LIMIT)) ? LW'(MAX_LIMIT) : lim_wide;
  assign m_sum     = m_r + (IW + 1)'(p_r);
  assign found_inc = (found_r == COUNT_MAX) ? found_r : found_r + COUNT_W'(1);
  assign p_wide    = PW'(p_r);

  always_comb begin
    lim_nxt     = lim_r;
    i_nxt       = i_r;
    p_nxt       = p_r;
    m_nxt       = m_r;
    found_nxt   = found_r;
    emitted_nxt = emitted_r;
    if (cmd.accept) begin
      lim_nxt     = lim_sat[IW-1:0];
      i_nxt       = '0;
      found_nxt   = '0;
      emitted_nxt = '0;
    end
    if (cmd.init_wr) begin
      if (i_r == lim_r) begin
        p_nxt = IW'(2);
      end else begin
        i_nxt = i_r + IW'(1);
      end
    end
    if (cmd.count) begin
      found_nxt = found_inc;
    end
    if (cmd.emit) begin
      emitted_nxt = emitted_r + EMIT_W'(1);
    end
    if (cmd.strike_start) begin
      m_nxt = sq_r[IW:0];
    end
    if (cmd.strike_wr) begin
      m_nxt = m_sum;
    end
    if (cmd.p_step) begin
      p_nxt = p_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r   <= '0;
      emitted_r <= '0;
      lim_r     <= '0;
      i_r       <= '0;
      p_r       <= '0;
      m_r       <= '0;
    end else begin
      found_r   <= found_nxt;
      emitted_r <= emitted_nxt;
      lim_r     <= lim_nxt;
      i_r       <= i_nxt;
      p_r       <= p_nxt;
      m_r       <= m_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      sq_r <= p_r * p_r;
    end
  end

  assign ram_we    = cmd.init_wr | cmd.strike_wr;
  assign ram_waddr = cmd.strike_wr ? m_r[IW-1:0] : i_r;
  assign ram_wdata = cmd.init_wr & (i_r >= IW'(2));

  psl_ram #(
    .WIDTH (1),
    .DEPTH (MAX_LIMIT + 1)
  ) u_mark_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (p_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.summary) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r <= p_wide[VALUE_W-1:0];
      out_item_r  <= 1'b1;
      out_count_r <= found_inc;
      out_last_r  <= 1'b0;
    end else if (cmd.summary) begin
      out_value_r <= '0;
      out_item_r  <= 1'b0;
      out_count_r <= found_r;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_prime_value   = out_value_r;
  assign out_is_prime_item = out_item_r;
  assign out_prime_count   = out_count_r;
  assign out_last          = out_last_r;

  assign sts.lim_small   = lim_sat < LW'(2);
  assign sts.idx_done    = i_r == lim_r;
  assign sts.mark        = ram_rdata;
  assign sts.sq_le       = sq_r <= (2 * IW)'(lim_r);
  assign sts.strike_done = m_sum > (IW + 1)'(lim_r);
  assign sts.p_last      = p_r == lim_r;
  assign sts.need_emit   = emitted_r < max_emitted;
  assign sts.slot_free   = !out_valid_r || !out_stall;

`include "prime_sieve_lister_core_assert.svh"

  `PSL_ASSERT(a_emit_budget, cmd.emit |-> (emitted_r < max_emitted), "prime beat over budget")
  `PSL_ASSERT(a_slot_free, (cmd.emit || cmd.summary) |-> sts.slot_free, "result overwritten")
  `PSL_ASSERT(a_strike_range, cmd.strike_wr |-> (m_r <= (IW + 1)'(lim_r)), "strike past limit")
  `PSL_ASSERT_NEXT(a_summary_last, cmd.summary, out_valid_r && out_last_r && !out_item_r, "bad summary")

endmodule

// ----- rtl/psl_ctrl.sv -----
// ----------------------------------------------------------------------------
// psl_ctrl
// Sequencer for fill, walk, strike and summary phases of one sieve run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psl_ctrl
  import psl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  psl_sts_t sts,
  output psl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INIT    = 3'd1;
  localparam logic [2:0] S_READ    = 3'd2;
  localparam logic [2:0] S_CHECK   = 3'd3;
  localparam logic [2:0] S_STRIKE  = 3'd4;
  localparam logic [2:0] S_SUMMARY = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.lim_small ? S_SUMMARY : S_INIT;
        end
      end
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.idx_done) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!sts.mark) begin
          if (sts.p_last) begin
            state_nxt = S_SUMMARY;
          end else begin
            cmd.p_step = 1'b1;
            state_nxt  = S_READ;
          end
        end else if (!sts.need_emit || sts.slot_free) begin
          cmd.count = 1'b1;
          cmd.emit  = sts.need_emit;
          if (sts.sq_le) begin
            cmd.strike_start = 1'b1;
            state_nxt        = S_STRIKE;
          end else if (sts.p_last) begin
            state_nxt = S_SUMMARY;
          end else begin
            cmd.p_step = 1'b1;
            state_nxt  = S_READ;
          end
        end
      end
      S_STRIKE: begin
        cmd.strike_wr = 1'b1;
        if (sts.strike_done) begin
          if (sts.p_last) begin
            state_nxt = S_SUMMARY;
          end else begin
            cmd.p_step = 1'b1;
            state_nxt  = S_READ;
          end
        end
      end
      S_SUMMARY: begin
        if (sts.slot_free) begin
          cmd.summary = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

endmodule

// ----- rtl/prime_sieve_lister_core.sv -----
// ----------------------------------------------------------------------------
// prime_sieve_lister_core
// Sieve of Eratosthenes over 0..limit, listing primes then a summary beat.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_limit
//   out      output     out_valid/out_stall out_prime_value, out_is_prime_item,
//                                           out_prime_count, out_last
//   cfg      input      APB psel/penable    max_emitted at byte address 0
//
// A run fills the mark store over 0..L, then walks each candidate 2..L (mark
// store read, then check) and strikes each multiple of a prime from its square,
// L being the saturated limit; the mark store has one write and one read port.
// A limit below two goes straight to summary. One item is in work at a time.
// Reset is synchronous; the mark store needs no clearing, every run fills it.
// Out stall holds the run only when a new result finds the result register full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_sieve_lister_core
  import psl_pkg::*;
#(
  parameter int MAX_LIMIT = MAX_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LIMIT_W-1:0]    in_limit,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_W-1:0]    out_prime_value,
  output logic                  out_is_prime_item,
  output logic [COUNT_W-1:0]    out_prime_count,
  output logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  psl_cmd_t          cmd;
  psl_sts_t          sts;
  logic [EMIT_W-1:0] max_emitted_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_emitted_r <= EMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_MAX_EMITTED) begin
      max_emitted_r <= pwdata[EMIT_W-1:0];
    end
  end

  assign prdata = (paddr == REG_MAX_EMITTED) ? CFG_DATA_W'(max_emitted_r) : '0;

  psl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  psl_datapath #(
    .MAX_LIMIT (MAX_LIMIT)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .max_emitted       (max_emitted_r),
    .in_limit          (in_limit),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_prime_value   (out_prime_value),
    .out_is_prime_item (out_is_prime_item),
    .out_prime_count   (out_prime_count),
    .out_last          (out_last)
  );

endmodule
